// File: sv/apsm_pkg.sv
// shared constants and types for the adaptive point smoother
package apsm_pkg;

    // default coordinate format, whole pixels and fraction bits
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 8;

    // configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register widths
    localparam int DEAD_W  = 8;
    localparam int SLOW_W  = 8;
    localparam int LIMIT_W = 10;
    localparam int GAIN_W  = 16;

    // alpha is Q0.16 with one extra bit so that 1.0 fits
    localparam int                 ALPHA_W    = GAIN_W + 1;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'h10000;
    localparam logic [GAIN_W-1:0]  BLEND_HALF = 16'h8000;

    // register reset values
    localparam logic [DEAD_W-1:0]  DEAD_ZONE_RST  = 8'd3;
    localparam logic [SLOW_W-1:0]  SLOW_LIMIT_RST = 8'd10;
    localparam logic [LIMIT_W-1:0] FAST_LIMIT_RST = 10'd50;
    localparam logic [GAIN_W-1:0]  SLOW_ALPHA_RST = 16'd3277;
    localparam logic [GAIN_W-1:0]  FAST_ALPHA_RST = 16'd45875;
    localparam logic [GAIN_W-1:0]  RAMP_SLOPE_RST = 16'd983;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEAD_ZONE  = 3'd0,
        CFG_SLOW_LIMIT = 3'd1,
        CFG_FAST_LIMIT = 3'd2,
        CFG_SLOW_ALPHA = 3'd3,
        CFG_FAST_ALPHA = 3'd4,
        CFG_RAMP_SLOPE = 3'd5
    } t_cfg_idx;

endpackage

// File: sv/adaptive_point_smoother.sv
// adaptive point smoother: dead band, distance-dependent gain, exponential blend
//
// Usage: raw points enter on the input channel (i_in_valid / o_in_stall) with
// a restart flag; one smoothed point leaves on the output channel
// (o_out_valid / i_out_stall) for every point taken. Registers are written
// through the config channel (i_cfg_valid / o_cfg_ready, always ready).
// One shared multiplier with a registered product and one accumulator do all
// arithmetic under a small sequencer; the square root runs one result bit
// per cycle, D = COORD_BITS + FRAC_BITS + 1 steps (21 at the defaults, one
// less when that sum exceeds 31).
// Path to o_out_valid: the first point after reset or restart goes straight
// to S_FIN; others pass the squares, the root and S_BAND, then the blend for
// each axis unless in the dead band, with S_RAMP and S_RINC in the ramp band.
// One point is in work at a time: o_in_stall is high from the input transfer
// until the result transfer, so no new point enters before the result leaves.
// While the receiver stalls, the result holds on the output ports.
// Reset restores the register defaults and drops the primed state, so the
// next point passes through unchanged.
module adaptive_point_smoother #(
    parameter int COORD_BITS = apsm_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = apsm_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [COORD_BITS-1:0]           i_raw_x,
    input  logic [COORD_BITS-1:0]           i_raw_y,
    input  logic                            i_restart,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [COORD_BITS-1:0]           o_out_x,
    output logic [COORD_BITS-1:0]           o_out_y,
    // config channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [apsm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [apsm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import apsm_pkg::*;

    // held point width and distance shift
    localparam int HW   = COORD_BITS + FRAC_BITS;
    localparam int DSH  = (HW > 31) ? 1 : 0;
    localparam int DW   = HW - DSH;
    localparam int SW   = 2 * DW + 1;
    localparam int LIMW = LIMIT_W + FRAC_BITS;
    localparam int CMPW = (HW + 1 > LIMW) ? HW + 1 : LIMW;
    localparam int MW0  = (HW > LIMW) ? HW : LIMW;
    localparam int MW   = (MW0 > ALPHA_W) ? MW0 : ALPHA_W;
    localparam int PW   = 2 * MW;
    localparam int AW   = PW + 1;
    localparam logic [AW-1:0] HALF_FRAC = AW'(1) << (FRAC_BITS - 1);

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_SQX  = 13'b0000000000010,
        S_SQY  = 13'b0000000000100,
        S_SUM  = 13'b0000000001000,
        S_ROOT = 13'b0000000010000,
        S_BAND = 13'b0000000100000,
        S_RAMP = 13'b0000001000000,
        S_RINC = 13'b0000010000000,
        S_BL0  = 13'b0000100000000,
        S_BL1  = 13'b0001000000000,
        S_BL2  = 13'b0010000000000,
        S_FIN  = 13'b0100000000000,
        S_OUT  = 13'b1000000000000
    } t_state;

    t_state               r_state, n_state;
    logic                 r_primed, n_primed;
    logic                 r_out_valid, n_out_valid;
    logic [DEAD_W-1:0]    r_dead_zone, n_dead_zone;
    logic [SLOW_W-1:0]    r_slow_limit, n_slow_limit;
    logic [LIMIT_W-1:0]   r_fast_limit, n_fast_limit;
    logic [GAIN_W-1:0]    r_slow_alpha, n_slow_alpha;
    logic [GAIN_W-1:0]    r_fast_alpha, n_fast_alpha;
    logic [GAIN_W-1:0]    r_ramp_slope, n_ramp_slope;
    logic [HW-1:0]        r_held_x, n_held_x;
    logic [HW-1:0]        r_held_y, n_held_y;
    logic [HW-1:0]        r_raw_x, n_raw_x;
    logic [HW-1:0]        r_raw_y, n_raw_y;
    logic                 r_sel_y, n_sel_y;
    logic [AW-1:0]        r_acc, n_acc;
    logic [SW-1:0]        r_root, n_root;
    logic [SW-1:0]        r_bit, n_bit;
    logic [PW-1:0]        r_prod;
    logic [ALPHA_W-1:0]   r_alpha, n_alpha;
    logic [COORD_BITS-1:0] r_out_x, n_out_x;
    logic [COORD_BITS-1:0] r_out_y, n_out_y;

    logic [HW-1:0]        diff_x, diff_y;
    logic [DW-1:0]        ax, ay;
    logic [CMPW-1:0]      dist_q, dead_q, slow_q, fast_q, over_w;
    logic [LIMW-1:0]      over;
    logic [MW-1:0]        mul_a, mul_b;
    logic [SW:0]          trial;
    logic [AW-1:0]        inc_w, alpha_sum, blend_sum;
    logic [ALPHA_W-1:0]   alpha_sat;
    logic [HW-1:0]        raw_sel, held_sel, blend_q;
    logic [HW:0]          rnd_x, rnd_y;
    logic [COORD_BITS:0]  pix_x, pix_y;
    logic [COORD_BITS-1:0] sat_x, sat_y;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_cfg_ready = 1'b1;

    // distance operands
    assign diff_x = (r_raw_x >= r_held_x) ? (r_raw_x - r_held_x) : (r_held_x - r_raw_x);
    assign diff_y = (r_raw_y >= r_held_y) ? (r_raw_y - r_held_y) : (r_held_y - r_raw_y);
    assign ax     = diff_x[HW-1:DSH];
    assign ay     = diff_y[HW-1:DSH];

    // band limits in the distance format
    assign dist_q = CMPW'(r_root[DW:0]) << DSH;
    assign dead_q = CMPW'(r_dead_zone) << FRAC_BITS;
    assign slow_q = CMPW'(r_slow_limit) << FRAC_BITS;
    assign fast_q = CMPW'(r_fast_limit) << FRAC_BITS;
    assign over_w = dist_q - slow_q;
    assign over   = over_w[LIMW-1:0];

    // square root trial value
    assign trial = (SW + 1)'(r_root) + (SW + 1)'(r_bit);

    // ramp alpha with saturation at 1.0
    assign inc_w     = (AW'(r_prod) + HALF_FRAC) >> FRAC_BITS;
    assign alpha_sum = AW'(r_slow_alpha) + inc_w;
    assign alpha_sat = (alpha_sum > AW'(ALPHA_ONE)) ? ALPHA_ONE : alpha_sum[ALPHA_W-1:0];

    // blend operands and result
    assign raw_sel   = r_sel_y ? r_raw_y : r_raw_x;
    assign held_sel  = r_sel_y ? r_held_y : r_held_x;
    assign blend_sum = r_acc + AW'(r_prod);
    assign blend_q   = blend_sum[GAIN_W +: HW];

    // round to whole pixels, saturating
    assign rnd_x = (HW + 1)'(r_held_x) + ((HW + 1)'(1) << (FRAC_BITS - 1));
    assign rnd_y = (HW + 1)'(r_held_y) + ((HW + 1)'(1) << (FRAC_BITS - 1));
    assign pix_x = rnd_x[HW:FRAC_BITS];
    assign pix_y = rnd_y[HW:FRAC_BITS];
    assign sat_x = pix_x[COORD_BITS] ? {COORD_BITS{1'b1}} : pix_x[COORD_BITS-1:0];
    assign sat_y = pix_y[COORD_BITS] ? {COORD_BITS{1'b1}} : pix_y[COORD_BITS-1:0];

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SQX: begin
                mul_a = MW'(ax);
                mul_b = MW'(ax);
            end
            S_SQY: begin
                mul_a = MW'(ay);
                mul_b = MW'(ay);
            end
            S_RAMP: begin
                mul_a = MW'(over);
                mul_b = MW'(r_ramp_slope);
            end
            S_BL0: begin
                mul_a = MW'(r_alpha);
                mul_b = MW'(raw_sel);
            end
            S_BL1: begin
                mul_a = MW'(ALPHA_ONE - r_alpha);
                mul_b = MW'(held_sel);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer and datapath next state
    always_comb begin
        n_state      = r_state;
        n_primed     = r_primed;
        n_out_valid  = r_out_valid;
        n_dead_zone  = r_dead_zone;
        n_slow_limit = r_slow_limit;
        n_fast_limit = r_fast_limit;
        n_slow_alpha = r_slow_alpha;
        n_fast_alpha = r_fast_alpha;
        n_ramp_slope = r_ramp_slope;
        n_held_x     = r_held_x;
        n_held_y     = r_held_y;
        n_raw_x      = r_raw_x;
        n_raw_y      = r_raw_y;
        n_sel_y      = r_sel_y;
        n_acc        = r_acc;
        n_root       = r_root;
        n_bit        = r_bit;
        n_alpha      = r_alpha;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;

        // register writes
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEAD_ZONE:  n_dead_zone  = i_cfg_data[DEAD_W-1:0];
                CFG_SLOW_LIMIT: n_slow_limit = i_cfg_data[SLOW_W-1:0];
                CFG_FAST_LIMIT: n_fast_limit = i_cfg_data[LIMIT_W-1:0];
                CFG_SLOW_ALPHA: n_slow_alpha = i_cfg_data[GAIN_W-1:0];
                CFG_FAST_ALPHA: n_fast_alpha = i_cfg_data[GAIN_W-1:0];
                CFG_RAMP_SLOPE: n_ramp_slope = i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            // take a point; the first one after reset or a restart point loads the state directly
            S_IDLE: begin
                if (i_in_valid) begin
                    n_raw_x = HW'(i_raw_x) << FRAC_BITS;
                    n_raw_y = HW'(i_raw_y) << FRAC_BITS;
                    if (i_restart || !r_primed) begin
                        n_held_x = HW'(i_raw_x) << FRAC_BITS;
                        n_held_y = HW'(i_raw_y) << FRAC_BITS;
                        n_primed = 1'b1;
                        n_state  = S_FIN;
                    end else begin
                        n_state = S_SQX;
                    end
                end
            end
            S_SQX: n_state = S_SQY;
            S_SQY: begin
                n_acc   = AW'(r_prod);
                n_state = S_SUM;
            end
            // sum of squares, start the root
            S_SUM: begin
                n_acc   = r_acc + AW'(r_prod);
                n_root  = '0;
                n_bit   = SW'(1) << (SW - 1);
                n_state = S_ROOT;
            end
            // one root bit per cycle
            S_ROOT: begin
                if (r_acc >= AW'(trial)) begin
                    n_acc  = r_acc - AW'(trial);
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_state = S_BAND;
                end
            end
            // pick the gain band
            S_BAND: begin
                n_sel_y = 1'b0;
                if (dist_q < dead_q) begin
                    n_state = S_FIN;
                end else if (dist_q < slow_q) begin
                    n_alpha = ALPHA_W'(r_slow_alpha);
                    n_state = S_BL0;
                end else if (dist_q > fast_q) begin
                    n_alpha = ALPHA_W'(r_fast_alpha);
                    n_state = S_BL0;
                end else begin
                    n_state = S_RAMP;
                end
            end
            S_RAMP: n_state = S_RINC;
            S_RINC: begin
                n_alpha = alpha_sat;
                n_state = S_BL0;
            end
            // blend: alpha*raw, then (1-alpha)*held, then sum
            S_BL0: n_state = S_BL1;
            S_BL1: begin
                n_acc   = AW'(r_prod) + AW'(BLEND_HALF);
                n_state = S_BL2;
            end
            S_BL2: begin
                if (r_sel_y) begin
                    n_held_y = blend_q;
                    n_state  = S_FIN;
                end else begin
                    n_held_x = blend_q;
                    n_sel_y  = 1'b1;
                    n_state  = S_BL0;
                end
            end
            // load the result register
            S_FIN: begin
                n_out_x     = sat_x;
                n_out_y     = sat_y;
                n_out_valid = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_primed     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_dead_zone  <= DEAD_ZONE_RST;
            r_slow_limit <= SLOW_LIMIT_RST;
            r_fast_limit <= FAST_LIMIT_RST;
            r_slow_alpha <= SLOW_ALPHA_RST;
            r_fast_alpha <= FAST_ALPHA_RST;
            r_ramp_slope <= RAMP_SLOPE_RST;
            r_held_x     <= '0;
            r_held_y     <= '0;
        end else begin
            r_state      <= n_state;
            r_primed     <= n_primed;
            r_out_valid  <= n_out_valid;
            r_dead_zone  <= n_dead_zone;
            r_slow_limit <= n_slow_limit;
            r_fast_limit <= n_fast_limit;
            r_slow_alpha <= n_slow_alpha;
            r_fast_alpha <= n_fast_alpha;
            r_ramp_slope <= n_ramp_slope;
            r_held_x     <= n_held_x;
            r_held_y     <= n_held_y;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_raw_x <= n_raw_x;
        r_raw_y <= n_raw_y;
        r_sel_y <= n_sel_y;
        r_acc   <= n_acc;
        r_root  <= n_root;
        r_bit   <= n_bit;
        r_prod  <= mul_a * mul_b;
        r_alpha <= n_alpha;
        r_out_x <= n_out_x;
        r_out_y <= n_out_y;
    end

    // a result is only offered while no new point can enter
    a_out_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("result offered while input open");

    // a restart point goes straight to the result stage
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_restart) |=> (r_state == S_FIN))
        else $error("restart point not passed through");

    // root iteration walks a single bit down
    a_root_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT) |-> $onehot(r_bit))
        else $error("root bit lost");

    // blend gain never exceeds one
    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BL1) |-> (r_alpha <= ALPHA_ONE))
        else $error("alpha above one");

endmodule
